// ----- rtl/snf_pkg.sv -----
package snf_pkg;

  localparam int HOST_W          = 24;
  localparam int CNT_W           = 16;
  localparam int BYTE_W          = 8;
  localparam int REQ_W           = 3;
  localparam int DEF_PAGE_BYTES  = 256;
  localparam int DEF_ADDR_BITS   = 24;
  localparam int DEF_QUEUE_DEPTH = 4;
  localparam int ID_BYTES        = 3;
  localparam int MAX_STEPS       = 9;
  localparam int IDX_W           = 4;

  localparam logic [BYTE_W-1:0] CMD_WREN  = 8'h06;
  localparam logic [BYTE_W-1:0] CMD_PP    = 8'h02;
  localparam logic [BYTE_W-1:0] CMD_READ  = 8'h03;
  localparam logic [BYTE_W-1:0] CMD_RDSR  = 8'h05;
  localparam logic [BYTE_W-1:0] CMD_SE    = 8'hD8;
  localparam logic [BYTE_W-1:0] CMD_CE    = 8'hC7;
  localparam logic [BYTE_W-1:0] CMD_RDID  = 8'h9F;
  localparam logic [BYTE_W-1:0] DUMMY_BYTE = 8'h00;

  typedef enum logic [REQ_W-1:0] {
    REQ_READ_ID,
    REQ_READ,
    REQ_PROGRAM,
    REQ_SECTOR_ERASE,
    REQ_CHIP_ERASE,
    REQ_DATA,
    REQ_RX
  } req_t;

  typedef enum logic [1:0] {
    K_XFER,
    K_REL,
    K_DATA,
    K_DONE
  } kind_t;

  typedef enum logic [3:0] {
    SQ_ID_START,
    SQ_READ_ZERO,
    SQ_READ_HDR,
    SQ_PAGE,
    SQ_REL_PAGE,
    SQ_SECTOR,
    SQ_CHIP,
    SQ_ID_END,
    SQ_DUMMY,
    SQ_READ_END,
    SQ_READ_MORE,
    SQ_PROG_BYTE,
    SQ_PROG_LAST,
    SQ_POLL_DONE
  } seq_t;

  typedef enum logic [3:0] {
    OP_CMD_RDID,
    OP_DUMMY,
    OP_CMD_READ,
    OP_CMD_WREN,
    OP_CMD_PP,
    OP_CMD_RDSR,
    OP_CMD_SE,
    OP_CMD_CE,
    OP_ADDR_HI,
    OP_ADDR_MID,
    OP_ADDR_LO,
    OP_TX_VAL,
    OP_REL,
    OP_DONE_ZERO,
    OP_DONE_VAL,
    OP_DATA_VAL
  } op_t;

  typedef struct packed {
    seq_t              seq;
    logic [HOST_W-1:0] val;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [IDX_W-1:0] seq_last(seq_t s);
    logic [IDX_W-1:0] n;
    case (s)
      SQ_ID_START:  n = 4'd1;
      SQ_READ_ZERO: n = 4'd5;
      SQ_READ_HDR:  n = 4'd4;
      SQ_PAGE:      n = 4'd5;
      SQ_REL_PAGE:  n = 4'd6;
      SQ_SECTOR:    n = 4'd8;
      SQ_CHIP:      n = 4'd5;
      SQ_ID_END:    n = 4'd2;
      SQ_DUMMY:     n = 4'd0;
      SQ_READ_END:  n = 4'd2;
      SQ_READ_MORE: n = 4'd1;
      SQ_PROG_BYTE: n = 4'd0;
      SQ_PROG_LAST: n = 4'd3;
      SQ_POLL_DONE: n = 4'd1;
      default:      n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic op_t seq_op(seq_t s, logic [IDX_W-1:0] i);
    op_t p [MAX_STEPS];
    p = '{default: OP_REL};
    case (s)
      SQ_ID_START:  p = '{0: OP_CMD_RDID, 1: OP_DUMMY, default: OP_REL};
      SQ_READ_ZERO: p = '{0: OP_CMD_READ, 1: OP_ADDR_HI, 2: OP_ADDR_MID, 3: OP_ADDR_LO,
                          4: OP_REL, 5: OP_DONE_ZERO, default: OP_REL};
      SQ_READ_HDR:  p = '{0: OP_CMD_READ, 1: OP_ADDR_HI, 2: OP_ADDR_MID, 3: OP_ADDR_LO,
                          4: OP_DUMMY, default: OP_REL};
      SQ_PAGE:      p = '{0: OP_CMD_WREN, 1: OP_REL, 2: OP_CMD_PP, 3: OP_ADDR_HI,
                          4: OP_ADDR_MID, 5: OP_ADDR_LO, default: OP_REL};
      SQ_REL_PAGE:  p = '{0: OP_REL, 1: OP_CMD_WREN, 2: OP_REL, 3: OP_CMD_PP,
                          4: OP_ADDR_HI, 5: OP_ADDR_MID, 6: OP_ADDR_LO, default: OP_REL};
      SQ_SECTOR:    p = '{0: OP_CMD_WREN, 1: OP_REL, 2: OP_CMD_SE, 3: OP_ADDR_HI,
                          4: OP_ADDR_MID, 5: OP_ADDR_LO, 6: OP_REL, 7: OP_CMD_RDSR,
                          8: OP_DUMMY, default: OP_REL};
      SQ_CHIP:      p = '{0: OP_CMD_WREN, 1: OP_REL, 2: OP_CMD_CE, 3: OP_REL,
                          4: OP_CMD_RDSR, 5: OP_DUMMY, default: OP_REL};
      SQ_ID_END:    p = '{0: OP_REL, 1: OP_DATA_VAL, 2: OP_DONE_ZERO, default: OP_REL};
      SQ_DUMMY:     p = '{0: OP_DUMMY, default: OP_REL};
      SQ_READ_END:  p = '{0: OP_DATA_VAL, 1: OP_REL, 2: OP_DONE_ZERO, default: OP_REL};
      SQ_READ_MORE: p = '{0: OP_DATA_VAL, 1: OP_DUMMY, default: OP_REL};
      SQ_PROG_BYTE: p = '{0: OP_TX_VAL, default: OP_REL};
      SQ_PROG_LAST: p = '{0: OP_TX_VAL, 1: OP_REL, 2: OP_CMD_RDSR, 3: OP_DUMMY,
                          default: OP_REL};
      SQ_POLL_DONE: p = '{0: OP_REL, 1: OP_DONE_VAL, default: OP_REL};
      default:      p = '{default: OP_REL};
    endcase
    return (i < IDX_W'(MAX_STEPS)) ? p[i] : OP_REL;
  endfunction

endpackage

// ----- rtl/snf_pgrem.sv -----
module snf_pgrem
  import snf_pkg::*;
#(
  parameter int PAGE_BYTES = DEF_PAGE_BYTES,
  parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [ADDR_BITS-1:0]               value,
  output logic                               done,
  output logic [$clog2(PAGE_BYTES)-1:0]      rem
);

  localparam int               REM_W   = $clog2(PAGE_BYTES);
  localparam int               SHIFT   = ADDR_BITS + REM_W;
  localparam int               MUL_W   = ADDR_BITS + 1;
  localparam int               PROD_W  = ADDR_BITS + MUL_W;
  localparam logic             POW2    = (PAGE_BYTES & (PAGE_BYTES - 1)) == 0;
  localparam longint unsigned  RECIP   = ((64'd1 << SHIFT) + 64'(PAGE_BYTES) - 64'd1) /
                                         64'(PAGE_BYTES);
  localparam logic [MUL_W-1:0] RECIP_V = MUL_W'(RECIP);
  localparam logic [REM_W-1:0] PAGE_V  = REM_W'(PAGE_BYTES);

  logic                 running;
  logic [PROD_W-1:0]    prod;
  logic [ADDR_BITS-1:0] held;
  logic [ADDR_BITS-1:0] quo;

  assign prod = PROD_W'(value) * PROD_W'(RECIP_V);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      held    <= '0;
      quo     <= '0;
      rem     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (POW2) begin
          rem  <= value[REM_W-1:0];
          done <= 1'b1;
        end else begin
          running <= 1'b1;
          held    <= value;
          quo     <= ADDR_BITS'(prod >> SHIFT);
        end
      end else if (running) begin
        running <= 1'b0;
        rem     <= REM_W'(held) - REM_W'(quo) * PAGE_V;
        done    <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/snf_queue.sv -----
module snf_queue
  import snf_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  entry_t  push_entry,
  input  logic    pop,
  output entry_t  head,
  output q_stat_t q_stat
);

  localparam int PTR_W = $clog2(DEPTH);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign head         = slots[rd_ptr];
  assign q_stat.full  = count == (PTR_W+1)'(DEPTH);
  assign q_stat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ----- rtl/snf_front.sv -----
module snf_front
  import snf_pkg::*;
#(
  parameter int PAGE_BYTES = DEF_PAGE_BYTES,
  parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [REQ_W-1:0]              req_type,
  input  logic [HOST_W-1:0]             address,
  input  logic [CNT_W-1:0]              byte_count,
  input  logic [BYTE_W-1:0]             data_byte,
  input  q_stat_t                       q_stat,
  output logic                          push,
  output entry_t                        push_entry,
  output logic                          pg_start,
  output logic [ADDR_BITS-1:0]          pg_value,
  input  logic                          pg_done,
  input  logic [$clog2(PAGE_BYTES)-1:0] pg_rem
);

  localparam int CHUNK_W = $clog2(PAGE_BYTES + 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ID,
    PH_READ,
    PH_PROG,
    PH_POLL
  } phase_t;

  phase_t               phase, phase_next;
  req_t                 op_held, op_held_next;
  logic [ADDR_BITS-1:0] current_address, current_address_next;
  logic [CNT_W-1:0]     bytes_left, bytes_left_next;
  logic [CHUNK_W-1:0]   chunk_left, chunk_left_next;
  logic [HOST_W-1:0]    id_shift, id_shift_next;
  logic                 busy, busy_next;

  logic                 accept;
  req_t                 rt;
  logic [ADDR_BITS-1:0] addr_m;
  logic [HOST_W-1:0]    addr_v;
  logic [HOST_W-1:0]    id_new;
  logic [CHUNK_W-1:0]   chunk_dec;
  logic [CNT_W-1:0]     bytes_dec;
  logic [CHUNK_W-1:0]   room;
  logic [CHUNK_W-1:0]   chunk_first;

  assign req_stall   = busy || q_stat.full;
  assign accept      = req_valid && !req_stall;
  assign rt          = req_t'(req_type);
  assign addr_m      = address[ADDR_BITS-1:0];
  assign addr_v      = HOST_W'(addr_m);
  assign id_new      = {id_shift[HOST_W-BYTE_W-1:0], data_byte};
  assign chunk_dec   = chunk_left - CHUNK_W'(chunk_left != '0);
  assign bytes_dec   = bytes_left - CNT_W'(bytes_left != '0);
  assign room        = CHUNK_W'(PAGE_BYTES) - CHUNK_W'(pg_rem);
  assign chunk_first = (bytes_left < CNT_W'(room)) ? CHUNK_W'(bytes_left) : room;

  always_comb begin
    phase_next           = phase;
    op_held_next         = op_held;
    current_address_next = current_address;
    bytes_left_next      = bytes_left;
    chunk_left_next      = chunk_left;
    id_shift_next        = id_shift;
    busy_next            = busy;
    push                 = 1'b0;
    push_entry.seq       = SQ_DUMMY;
    push_entry.val       = '0;
    pg_start             = 1'b0;
    pg_value             = current_address;

    if (busy) begin
      if (pg_done) begin
        busy_next       = 1'b0;
        chunk_left_next = chunk_first;
      end
    end else if (accept) begin
      case (phase)
        PH_IDLE: begin
          case (rt)
            REQ_READ_ID: begin
              id_shift_next   = '0;
              chunk_left_next = CHUNK_W'(ID_BYTES);
              push            = 1'b1;
              push_entry.seq  = SQ_ID_START;
              phase_next      = PH_ID;
            end
            REQ_READ: begin
              push           = 1'b1;
              push_entry.val = addr_v;
              if (byte_count == '0) begin
                push_entry.seq = SQ_READ_ZERO;
              end else begin
                bytes_left_next = byte_count;
                push_entry.seq  = SQ_READ_HDR;
                phase_next      = PH_READ;
              end
            end
            REQ_PROGRAM: begin
              if (byte_count != '0) begin
                op_held_next         = REQ_PROGRAM;
                current_address_next = addr_m;
                bytes_left_next      = byte_count;
                push                 = 1'b1;
                push_entry.seq       = SQ_PAGE;
                push_entry.val       = addr_v;
                pg_start             = 1'b1;
                pg_value             = addr_m;
                busy_next            = 1'b1;
                phase_next           = PH_PROG;
              end
            end
            REQ_SECTOR_ERASE: begin
              op_held_next   = REQ_SECTOR_ERASE;
              push           = 1'b1;
              push_entry.seq = SQ_SECTOR;
              push_entry.val = addr_v;
              phase_next     = PH_POLL;
            end
            REQ_CHIP_ERASE: begin
              op_held_next   = REQ_CHIP_ERASE;
              push           = 1'b1;
              push_entry.seq = SQ_CHIP;
              phase_next     = PH_POLL;
            end
            default: ;
          endcase
        end
        PH_ID: begin
          if (rt == REQ_RX) begin
            id_shift_next   = id_new;
            chunk_left_next = chunk_dec;
            push            = 1'b1;
            if (chunk_dec == '0) begin
              push_entry.seq = SQ_ID_END;
              push_entry.val = id_new;
              phase_next     = PH_IDLE;
            end
          end
        end
        PH_READ: begin
          if (rt == REQ_RX) begin
            bytes_left_next = bytes_dec;
            push            = 1'b1;
            push_entry.val  = HOST_W'(data_byte);
            if (bytes_dec == '0) begin
              push_entry.seq = SQ_READ_END;
              phase_next     = PH_IDLE;
            end else begin
              push_entry.seq = SQ_READ_MORE;
            end
          end
        end
        PH_PROG: begin
          if (rt == REQ_DATA) begin
            current_address_next = current_address + 1'b1;
            bytes_left_next      = bytes_dec;
            chunk_left_next      = chunk_dec;
            push                 = 1'b1;
            push_entry.val       = HOST_W'(data_byte);
            if (chunk_dec == '0) begin
              push_entry.seq = SQ_PROG_LAST;
              phase_next     = PH_POLL;
            end else begin
              push_entry.seq = SQ_PROG_BYTE;
            end
          end
        end
        PH_POLL: begin
          if (rt == REQ_RX) begin
            push = 1'b1;
            if (data_byte[0]) begin
              push_entry.seq = SQ_DUMMY;
            end else if (op_held == REQ_PROGRAM && bytes_left != '0) begin
              push_entry.seq = SQ_REL_PAGE;
              push_entry.val = HOST_W'(current_address);
              pg_start       = 1'b1;
              busy_next      = 1'b1;
              phase_next     = PH_PROG;
            end else begin
              push_entry.seq = SQ_POLL_DONE;
              push_entry.val = (op_held == REQ_PROGRAM) ? HOST_W'(current_address) : '0;
              phase_next     = PH_IDLE;
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      op_held         <= REQ_READ_ID;
      current_address <= '0;
      bytes_left      <= '0;
      chunk_left      <= '0;
      id_shift        <= '0;
      busy            <= 1'b0;
    end else begin
      phase           <= phase_next;
      op_held         <= op_held_next;
      current_address <= current_address_next;
      bytes_left      <= bytes_left_next;
      chunk_left      <= chunk_left_next;
      id_shift        <= id_shift_next;
      busy            <= busy_next;
    end
  end

endmodule

// ----- rtl/snf_back.sv -----
module snf_back
  import snf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  q_stat_t           q_stat,
  input  entry_t            head,
  output logic              pop,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [1:0]        out_kind,
  output logic [BYTE_W-1:0] tx_byte,
  output logic [HOST_W-1:0] host_data,
  output logic              last
);

  entry_t            cur;
  logic              cur_valid;
  logic [IDX_W-1:0]  idx;
  logic              load_ok;
  logic              fire;
  logic              last_step;
  op_t               op;
  kind_t             kind_n;
  logic [BYTE_W-1:0] tx_n;
  logic [HOST_W-1:0] hd_n;

  assign load_ok   = !rsp_valid || !rsp_stall;
  assign fire      = cur_valid && load_ok;
  assign last_step = idx == seq_last(cur.seq);
  assign pop       = !q_stat.empty && (!cur_valid || (fire && last_step));
  assign op        = seq_op(cur.seq, idx);

  always_comb begin
    kind_n = K_XFER;
    tx_n   = '0;
    hd_n   = '0;
    case (op)
      OP_CMD_RDID:  tx_n = CMD_RDID;
      OP_DUMMY:     tx_n = DUMMY_BYTE;
      OP_CMD_READ:  tx_n = CMD_READ;
      OP_CMD_WREN:  tx_n = CMD_WREN;
      OP_CMD_PP:    tx_n = CMD_PP;
      OP_CMD_RDSR:  tx_n = CMD_RDSR;
      OP_CMD_SE:    tx_n = CMD_SE;
      OP_CMD_CE:    tx_n = CMD_CE;
      OP_ADDR_HI:   tx_n = cur.val[23:16];
      OP_ADDR_MID:  tx_n = cur.val[15:8];
      OP_ADDR_LO:   tx_n = cur.val[7:0];
      OP_TX_VAL:    tx_n = cur.val[7:0];
      OP_REL:       kind_n = K_REL;
      OP_DONE_ZERO: kind_n = K_DONE;
      OP_DONE_VAL: begin
        kind_n = K_DONE;
        hd_n   = cur.val;
      end
      OP_DATA_VAL: begin
        kind_n = K_DATA;
        hd_n   = cur.val;
      end
      default: kind_n = K_REL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (fire) begin
        if (last_step) begin
          cur_valid <= 1'b0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      if (load_ok) begin
        rsp_valid <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (fire) begin
      out_kind  <= kind_n;
      tx_byte   <= tx_n;
      host_data <= hd_n;
      last      <= last_step;
    end
  end

endmodule

// ----- rtl/spi_nor_flash_sequencer.sv -----
// SPI NOR flash command sequencer, 24-bit addressing.
// Request channel (req_valid / req_stall): host requests (read id, read,
// program, sector erase, chip erase), program data words and words received
// back from the flash. Response channel (rsp_valid / rsp_stall): SPI byte
// transfers, chip select releases, host data and done marks; last flags the
// final response word of a request word.
// Throughput: one request word per cycle while req_stall is low and one
// response word per cycle while rsp_stall is low. A request word expands
// to 0 to 9 response words, so the response channel sets the sustained
// rate. A page start (program request, or poll end with bytes remaining)
// holds req_stall until the page offset unit is done; if PAGE_BYTES is not
// a power of two, that unit first registers a reciprocal-multiply quotient.
// Response path: QUEUE_DEPTH queue, current entry and response registers.
// Reset: phase idle, queue empty, rsp_valid low.
// Stall: rsp_stall holds the response register; requests are still taken
// until the command queue fills, then req_stall rises.
module spi_nor_flash_sequencer
  import snf_pkg::*;
#(
  parameter int PAGE_BYTES  = DEF_PAGE_BYTES,
  parameter int ADDR_BITS   = DEF_ADDR_BITS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [HOST_W-1:0] address,
  input  logic [CNT_W-1:0]  byte_count,
  input  logic [BYTE_W-1:0] data_byte,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [1:0]        out_kind,
  output logic [BYTE_W-1:0] tx_byte,
  output logic [HOST_W-1:0] host_data,
  output logic              last
);

  q_stat_t                       q_stat;
  logic                          push;
  entry_t                        push_entry;
  logic                          pop;
  entry_t                        head;
  logic                          pg_start;
  logic [ADDR_BITS-1:0]          pg_value;
  logic                          pg_done;
  logic [$clog2(PAGE_BYTES)-1:0] pg_rem;

  snf_front #(
    .PAGE_BYTES(PAGE_BYTES),
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .address   (address),
    .byte_count(byte_count),
    .data_byte (data_byte),
    .q_stat    (q_stat),
    .push      (push),
    .push_entry(push_entry),
    .pg_start  (pg_start),
    .pg_value  (pg_value),
    .pg_done   (pg_done),
    .pg_rem    (pg_rem)
  );

  snf_pgrem #(
    .PAGE_BYTES(PAGE_BYTES),
    .ADDR_BITS (ADDR_BITS)
  ) u_pgrem (
    .clk  (clk),
    .rst  (rst),
    .start(pg_start),
    .value(pg_value),
    .done (pg_done),
    .rem  (pg_rem)
  );

  snf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  snf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .head     (head),
    .pop      (pop),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .out_kind (out_kind),
    .tx_byte  (tx_byte),
    .host_data(host_data),
    .last     (last)
  );

endmodule

// ----- rtl/snf_checker.sv -----
module snf_checker
  import snf_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input logic [1:0]        out_kind,
  input logic [BYTE_W-1:0] tx_byte,
  input logic [HOST_W-1:0] host_data,
  input logic              last
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("response word dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && out_kind == K_DONE |-> last)
    else $error("done word not final");

  a_tx_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && out_kind != K_XFER |-> tx_byte == '0)
    else $error("tx byte set on non-transfer word");

  a_host_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (out_kind == K_XFER || out_kind == K_REL) |-> host_data == '0)
    else $error("host data set on transfer or release word");

endmodule

bind spi_nor_flash_sequencer snf_checker u_snf_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import snf_pkg::*;

  localparam int                WATCHDOG_LIMIT = 2000;
  localparam int                RAND_WORDS     = 230;
  localparam int                N_DIR          = 26;
  localparam int                N_DIR_RSP      = 8;
  localparam logic [REQ_W-1:0]  REQ_UNUSED     = 3'd7;

  typedef enum logic [2:0] {FP_IDLE, FP_ID, FP_READ, FP_PROG, FP_POLL} flash_phase_t;
  typedef enum int {ST_NONE, ST_EVERY3, ST_COIN, ST_HEAVY} stall_mode_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] tx;
    logic [HOST_W-1:0] hd;
    logic              lst;
  } flash_rsp_t;

  typedef struct packed {
    logic [REQ_W-1:0]  rt;
    logic [HOST_W-1:0] addr;
    logic [CNT_W-1:0]  cnt;
    logic [BYTE_W-1:0] db;
    logic              typed;
    logic [IDX_W-1:0]  n_typed;
  } dir_row_t;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              req_valid  = 1'b0;
  logic              req_stall;
  logic [REQ_W-1:0]  req_type   = '0;
  logic [HOST_W-1:0] address    = '0;
  logic [CNT_W-1:0]  byte_count = '0;
  logic [BYTE_W-1:0] data_byte  = '0;
  logic              rsp_valid;
  logic              rsp_stall  = 1'b0;
  logic [1:0]        out_kind;
  logic [BYTE_W-1:0] tx_byte;
  logic [HOST_W-1:0] host_data;
  logic              last;

  flash_phase_t      fl_phase = FP_IDLE;
  req_t              fl_op    = REQ_READ_ID;
  logic [HOST_W-1:0] fl_addr  = '0;
  logic [CNT_W-1:0]  fl_left  = '0;
  logic [8:0]        fl_chunk = '0;
  logic [HOST_W-1:0] fl_id    = '0;

  flash_rsp_t  step_rsp [$];
  flash_rsp_t  rsp_due [$];
  dir_row_t    dir_tab [N_DIR];
  flash_rsp_t  dir_rsp [N_DIR_RSP];

  int          fails       = 0;
  int          idle_cycles = 0;
  int          burst_left  = 0;
  bit          steady      = 1'b0;
  stall_mode_t stall_mode  = ST_NONE;
  int          mode_left   = 0;
  int          pat_cnt     = 0;

  spi_nor_flash_sequencer u_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .address    (address),
    .byte_count (byte_count),
    .data_byte  (data_byte),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .out_kind   (out_kind),
    .tx_byte    (tx_byte),
    .host_data  (host_data),
    .last       (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void add_rsp(kind_t k, logic [BYTE_W-1:0] tx, logic [HOST_W-1:0] hd);
    step_rsp.push_back('{k, tx, hd, 1'b0});
  endfunction

  function automatic void add_addr(logic [HOST_W-1:0] a);
    add_rsp(K_XFER, a[23:16], '0);
    add_rsp(K_XFER, a[15:8], '0);
    add_rsp(K_XFER, a[7:0], '0);
  endfunction

  function automatic void start_poll();
    add_rsp(K_XFER, CMD_RDSR, '0);
    add_rsp(K_XFER, DUMMY_BYTE, '0);
    fl_phase = FP_POLL;
  endfunction

  function automatic void open_page();
    int room;
    room = DEF_PAGE_BYTES - (int'(fl_addr) % DEF_PAGE_BYTES);
    fl_chunk = 9'((room < int'(fl_left)) ? room : int'(fl_left));
    add_rsp(K_XFER, CMD_WREN, '0);
    add_rsp(K_REL, '0, '0);
    add_rsp(K_XFER, CMD_PP, '0);
    add_addr(fl_addr);
    fl_phase = FP_PROG;
  endfunction

  function automatic void flash_step(logic [REQ_W-1:0] rt, logic [HOST_W-1:0] a,
                                     logic [CNT_W-1:0] c, logic [BYTE_W-1:0] d);
    step_rsp.delete();
    case (fl_phase)
      FP_IDLE: begin
        case (rt)
          REQ_READ_ID: begin
            fl_id    = '0;
            fl_chunk = 9'(ID_BYTES);
            add_rsp(K_XFER, CMD_RDID, '0);
            add_rsp(K_XFER, DUMMY_BYTE, '0);
            fl_phase = FP_ID;
          end
          REQ_READ: begin
            add_rsp(K_XFER, CMD_READ, '0);
            add_addr(a);
            if (c == '0) begin
              add_rsp(K_REL, '0, '0);
              add_rsp(K_DONE, '0, '0);
            end else begin
              fl_left = c;
              add_rsp(K_XFER, DUMMY_BYTE, '0);
              fl_phase = FP_READ;
            end
          end
          REQ_PROGRAM: begin
            if (c != '0) begin
              fl_op   = REQ_PROGRAM;
              fl_addr = a;
              fl_left = c;
              open_page();
            end
          end
          REQ_SECTOR_ERASE: begin
            fl_op = REQ_SECTOR_ERASE;
            add_rsp(K_XFER, CMD_WREN, '0);
            add_rsp(K_REL, '0, '0);
            add_rsp(K_XFER, CMD_SE, '0);
            add_addr(a);
            add_rsp(K_REL, '0, '0);
            start_poll();
          end
          REQ_CHIP_ERASE: begin
            fl_op = REQ_CHIP_ERASE;
            add_rsp(K_XFER, CMD_WREN, '0);
            add_rsp(K_REL, '0, '0);
            add_rsp(K_XFER, CMD_CE, '0);
            add_rsp(K_REL, '0, '0);
            start_poll();
          end
          default: ;
        endcase
      end
      FP_ID: begin
        if (rt == REQ_RX) begin
          fl_id = {fl_id[15:0], d};
          if (fl_chunk != '0) fl_chunk--;
          if (fl_chunk == '0) begin
            add_rsp(K_REL, '0, '0);
            add_rsp(K_DATA, '0, fl_id);
            add_rsp(K_DONE, '0, '0);
            fl_phase = FP_IDLE;
          end else begin
            add_rsp(K_XFER, DUMMY_BYTE, '0);
          end
        end
      end
      FP_READ: begin
        if (rt == REQ_RX) begin
          add_rsp(K_DATA, '0, HOST_W'(d));
          if (fl_left != '0) fl_left--;
          if (fl_left == '0) begin
            add_rsp(K_REL, '0, '0);
            add_rsp(K_DONE, '0, '0);
            fl_phase = FP_IDLE;
          end else begin
            add_rsp(K_XFER, DUMMY_BYTE, '0);
          end
        end
      end
      FP_PROG: begin
        if (rt == REQ_DATA) begin
          add_rsp(K_XFER, d, '0);
          fl_addr = fl_addr + 1'b1;
          if (fl_left != '0) fl_left--;
          if (fl_chunk != '0) fl_chunk--;
          if (fl_chunk == '0) begin
            add_rsp(K_REL, '0, '0);
            start_poll();
          end
        end
      end
      default: begin
        if (rt == REQ_RX) begin
          if (d[0]) begin
            add_rsp(K_XFER, DUMMY_BYTE, '0);
          end else begin
            add_rsp(K_REL, '0, '0);
            if (fl_op == REQ_PROGRAM && fl_left != '0) begin
              open_page();
            end else begin
              add_rsp(K_DONE, '0, (fl_op == REQ_PROGRAM) ? fl_addr : '0);
              fl_phase = FP_IDLE;
            end
          end
        end
      end
    endcase
    if (step_rsp.size() > 0) step_rsp[step_rsp.size() - 1].lst = 1'b1;
  endfunction

  task automatic put_word(input logic [REQ_W-1:0] rt, input logic [HOST_W-1:0] a,
                          input logic [CNT_W-1:0] c, input logic [BYTE_W-1:0] d,
                          input bit keep, output int n_rsp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid  <= 1'b1;
    req_type   <= rt;
    address    <= a;
    byte_count <= c;
    data_byte  <= d;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    flash_step(rt, a, c, d);
    n_rsp = step_rsp.size();
    if (keep) foreach (step_rsp[i]) rsp_due.push_back(step_rsp[i]);
  endtask

  task automatic random_word(output int n_rsp);
    logic [REQ_W-1:0]  rt;
    logic [HOST_W-1:0] a;
    logic [CNT_W-1:0]  c;
    logic [BYTE_W-1:0] d;
    a = HOST_W'($urandom);
    c = CNT_W'($urandom);
    d = BYTE_W'($urandom);
    if ($urandom_range(0, 11) == 0) begin
      if (fl_phase == FP_IDLE) rt = REQ_W'($urandom_range(REQ_DATA, REQ_UNUSED));
      else rt = REQ_W'($urandom_range(REQ_READ_ID, REQ_UNUSED));
    end else begin
      case (fl_phase)
        FP_IDLE: begin
          rt = REQ_W'($urandom_range(REQ_READ_ID, REQ_CHIP_ERASE));
          if (rt == REQ_READ) begin
            c = CNT_W'($urandom_range(0, 6));
          end else if (rt == REQ_PROGRAM) begin
            c = CNT_W'(($urandom_range(0, 11) == 0) ? $urandom_range(257, 280)
                                                    : $urandom_range(0, 12));
            if ($urandom_range(0, 1) == 1) a[7:0] = 8'hFF - 8'($urandom_range(0, 7));
            if ($urandom_range(0, 7) == 0) a[23:8] = '1;
          end
        end
        FP_ID, FP_READ: rt = REQ_RX;
        FP_PROG: rt = REQ_DATA;
        default: begin
          rt = REQ_RX;
          d[0] = ($urandom_range(0, 2) == 0);
        end
      endcase
    end
    put_word(rt, a, c, d, 1'b1, n_rsp);
  endtask

  // receiver: hold each stall pattern for a random stretch
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(ST_NONE, ST_HEAVY));
      mode_left  <= $urandom_range(40, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    pat_cnt <= pat_cnt + 1;
    case (stall_mode)
      ST_NONE:   rsp_stall <= 1'b0;
      ST_EVERY3: rsp_stall <= (pat_cnt % 3 == 2);
      ST_COIN:   rsp_stall <= ($urandom_range(0, 1) == 1);
      default:   rsp_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    flash_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_due.size() == 0) begin
        $error("unexpected response word: out_kind %0d tx_byte %02h host_data %06h last %0d",
               out_kind, tx_byte, host_data, last);
        fails++;
      end else begin
        want = rsp_due.pop_front();
        if (out_kind !== want.kind) begin
          $error("out_kind: expected %0d, actual %0d", want.kind, out_kind);
          fails++;
        end
        if (tx_byte !== want.tx) begin
          $error("tx_byte: expected %02h, actual %02h", want.tx, tx_byte);
          fails++;
        end
        if (host_data !== want.hd) begin
          $error("host_data: expected %06h, actual %06h", want.hd, host_data);
          fails++;
        end
        if (last !== want.lst) begin
          $error("last: expected %0d, actual %0d", want.lst, last);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int k;
    int n;
    int taken;
    dir_rsp = '{
      '{K_XFER, CMD_RDID, 24'h0, 1'b0},
      '{K_XFER, DUMMY_BYTE, 24'h0, 1'b1},
      '{K_XFER, CMD_READ, 24'h0, 1'b0},
      '{K_XFER, 8'hFF, 24'h0, 1'b0},
      '{K_XFER, 8'hFF, 24'h0, 1'b0},
      '{K_XFER, 8'hFF, 24'h0, 1'b0},
      '{K_REL, 8'h00, 24'h0, 1'b0},
      '{K_DONE, 8'h00, 24'h0, 1'b1}
    };
    dir_tab = '{
      '{REQ_READ_ID,      24'h000000, 16'h0000, 8'h00, 1'b1, 4'd2},
      '{REQ_RX,           24'h000000, 16'h0000, 8'hFF, 1'b0, 4'd0},
      '{REQ_RX,           24'h000000, 16'h0000, 8'h00, 1'b0, 4'd0},
      '{REQ_RX,           24'h000000, 16'h0000, 8'hA5, 1'b0, 4'd0},
      '{REQ_READ,         24'hFFFFFF, 16'h0000, 8'h00, 1'b1, 4'd6},
      '{REQ_READ,         24'h000000, 16'h0002, 8'h00, 1'b0, 4'd0},
      '{REQ_PROGRAM,      24'hFFFFFF, 16'hFFFF, 8'hFF, 1'b1, 4'd0},
      '{REQ_DATA,         24'h000000, 16'h0000, 8'h3C, 1'b1, 4'd0},
      '{REQ_RX,           24'h000000, 16'h0000, 8'h00, 1'b0, 4'd0},
      '{REQ_RX,           24'h000000, 16'h0000, 8'hFF, 1'b0, 4'd0},
      '{REQ_UNUSED,       24'hFFFFFF, 16'hFFFF, 8'hFF, 1'b1, 4'd0},
      '{REQ_RX,           24'h000000, 16'h0000, 8'h00, 1'b1, 4'd0},
      '{REQ_DATA,         24'h000000, 16'h0000, 8'h11, 1'b1, 4'd0},
      '{REQ_PROGRAM,      24'h123456, 16'h0000, 8'h00, 1'b1, 4'd0},
      '{REQ_PROGRAM,      24'hFFFFFE, 16'h0003, 8'h00, 1'b0, 4'd0},
      '{REQ_DATA,         24'h000000, 16'h0000, 8'h00, 1'b0, 4'd0},
      '{REQ_DATA,         24'h000000, 16'h0000, 8'hFF, 1'b0, 4'd0},
      '{REQ_RX,           24'h000000, 16'h0000, 8'h01, 1'b0, 4'd0},
      '{REQ_RX,           24'h000000, 16'h0000, 8'h00, 1'b0, 4'd0},
      '{REQ_DATA,         24'h000000, 16'h0000, 8'h5A, 1'b0, 4'd0},
      '{REQ_RX,           24'h000000, 16'h0000, 8'hFE, 1'b0, 4'd0},
      '{REQ_SECTOR_ERASE, 24'hABCDEF, 16'h0000, 8'h00, 1'b0, 4'd0},
      '{REQ_RX,           24'h000000, 16'h0000, 8'hFF, 1'b0, 4'd0},
      '{REQ_RX,           24'h000000, 16'h0000, 8'h00, 1'b0, 4'd0},
      '{REQ_CHIP_ERASE,   24'h000000, 16'h0000, 8'h00, 1'b0, 4'd0},
      '{REQ_RX,           24'h000000, 16'h0000, 8'h00, 1'b0, 4'd0}
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    k = 0;
    foreach (dir_tab[i]) begin
      put_word(dir_tab[i].rt, dir_tab[i].addr, dir_tab[i].cnt, dir_tab[i].db,
               !dir_tab[i].typed, n);
      if (dir_tab[i].typed) begin
        repeat (int'(dir_tab[i].n_typed)) begin
          rsp_due.push_back(dir_rsp[k]);
          k++;
        end
      end
    end

    // drain any open operation before leaving the random part
    taken = 0;
    while (taken < RAND_WORDS || fl_phase != FP_IDLE) begin
      steady = (taken >= 100 && taken < 150);
      random_word(n);
      if (n > 0) taken++;
    end

    req_valid <= 1'b0;

    while (rsp_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- spi_nor_flash_sequencer.f -----
rtl/snf_pkg.sv
rtl/snf_pgrem.sv
rtl/snf_queue.sv
rtl/snf_front.sv
rtl/snf_back.sv
rtl/spi_nor_flash_sequencer.sv
rtl/snf_checker.sv
tb/sv/tb_top.sv
